>>> rtl/atilt_pkg.sv
// ----------------------------------------------------------------------------
// atilt_pkg: shared constants and tables for the tilt angle block
// Field widths, fixed-point formats, the CORDIC arctangent table and the
// radian to degree scale used by accel_tilt_angles_with_level_bias.
// ----------------------------------------------------------------------------
package atilt_pkg;

  // Default parameter values
  localparam int SAMPLE_BITS_DEF      = 16;
  localparam int ANGLE_ITERATIONS_DEF = 20;

  // Port field widths
  localparam int FIELD_W    = 16;
  localparam int IN_DATA_W  = 48;
  localparam int TILT_X_W   = 9;
  localparam int TILT_Y_W   = 10;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - TILT_X_W - TILT_Y_W;

  // CORDIC operands are Q16, angles are Q32 radians
  localparam int FRAC_BITS = 16;
  localparam int ANGLE_W   = 36;
  localparam int TAB_IDX_W = 5;

  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 36'sd6746518852;

  // Shared multiplier and accumulator
  localparam int MUL_A_W   = 18;
  localparam int MUL_B_W   = 27;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MAG_SPLIT = 17;
  localparam int ACC_W     = 61;

  // 180/pi in Q20, product is Q52
  localparam logic [25:0] DEG_Q20  = 26'd60078979;
  localparam int          DEG_FRAC = 52;
  localparam int          DEG_W    = 10;

  // Stored level biases
  localparam int BIAS_X_W = 8;
  localparam int BIAS_Y_W = 9;

  // atan(2^-i) in Q32 radians, rounded to nearest
  function automatic logic signed [ANGLE_W-1:0] atan_q32(input logic [TAB_IDX_W-1:0] idx);
    logic signed [ANGLE_W-1:0] v;
    case (idx)
      5'd0:    v = 36'sd3373259426;
      5'd1:    v = 36'sd1991351318;
      5'd2:    v = 36'sd1052175346;
      5'd3:    v = 36'sd534100635;
      5'd4:    v = 36'sd268086748;
      5'd5:    v = 36'sd134174063;
      5'd6:    v = 36'sd67103403;
      5'd7:    v = 36'sd33553749;
      5'd8:    v = 36'sd16777131;
      5'd9:    v = 36'sd8388597;
      5'd10:   v = 36'sd4194303;
      default: v = 36'sd1 <<< (6'd32 - {1'b0, idx});
    endcase
    return v;
  endfunction

endpackage

>>> rtl/accel_tilt_angles_with_level_bias.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles_with_level_bias: tilt angles from one accelerometer word
// Forms atan2(y, hypot(x,z)) and atan2(x, z) in whole degrees with a shared
// vectoring CORDIC, square root and multiplier, then removes level biases.
// ----------------------------------------------------------------------------
// The result is valid sooner when an angle has both operands zero, which skips
// its CORDIC iterations. The pace is set by the bit-serial square root and the
// CORDIC iterations run once per angle; a new word is accepted only in idle,
// once the previous word has left the sequencer.
// A result waiting in the output register does not block the next input word.
// Reset (synchronous, rst high) idles the sequencer, drops the output word and
// clears both level biases to zero.
module accel_tilt_angles_with_level_bias
  import atilt_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // accel_x, accel_y, accel_z
  input  logic [0:0]            s_axis_tuser,   // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // tilt_x, tilt_y, zero pad
);

  localparam int SB      = SAMPLE_BITS;
  localparam int CW      = SAMPLE_BITS + FRAC_BITS + 4;
  localparam int ROOT_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int SQ_W    = 2 * SAMPLE_BITS;
  localparam int IT_W    = $clog2(ANGLE_ITERATIONS);
  localparam int RT_W    = $clog2(ROOT_W);
  localparam int STEP_W  = (IT_W > RT_W) ? IT_W : RT_W;
  localparam int DROP    = FIELD_W - SAMPLE_BITS;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SQX    = 13'b0000000000010,
    S_SQZ    = 13'b0000000000100,
    S_SQACC  = 13'b0000000001000,
    S_SQRT   = 13'b0000000010000,
    S_LOAD   = 13'b0000000100000,
    S_PRE    = 13'b0000001000000,
    S_ROT    = 13'b0000010000000,
    S_DLO    = 13'b0000100000000,
    S_DHI    = 13'b0001000000000,
    S_DACC   = 13'b0010000000000,
    S_DSTORE = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state;

  // Sample and sequencing registers
  logic signed [SB-1:0]      xs, ys, zs;
  logic                      kind_r;
  logic                      sel;
  logic [STEP_W-1:0]         step;

  // Shared multiplier and accumulator
  logic signed [MUL_P_W-1:0] prod;
  logic [ACC_W-1:0]          acc_m;

  // Square root
  logic [RAD_W-1:0]          rad;
  logic [REM_W-1:0]          rem;
  logic [ROOT_W-1:0]         root;

  // CORDIC
  logic signed [CW-1:0]      cx, cy;
  logic signed [ANGLE_W-1:0] ang;

  // Angles, biases, output word
  logic signed [DEG_W-1:0]    ax, ay;
  logic signed [BIAS_X_W-1:0] bias_x;
  logic signed [BIAS_Y_W-1:0] bias_y;
  logic                       out_valid;
  logic [TILT_X_W-1:0]        out_tx;
  logic [TILT_Y_W-1:0]        out_ty;

  // Combinational helpers
  logic signed [SB-1:0]      in_x, in_y, in_z;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [ANGLE_W-1:0]        mag;
  logic [REM_W-1:0]          rem_sh;
  logic [REM_W-1:0]          trial;
  logic [ACC_W-1:0]          sq_sum;
  logic signed [CW-1:0]      sh_x, sh_y;
  logic signed [ANGLE_W-1:0] tab;
  logic [DEG_W-1:0]          deg_mag;
  logic signed [DEG_W-1:0]   deg;
  logic                      out_free;
  logic [TILT_X_W-1:0]       tx_next;
  logic [TILT_Y_W-1:0]       ty_next;

  // Keep the top SAMPLE_BITS of each axis, rounding toward minus infinity
  assign in_x = SB'($signed(s_axis_tdata[FIELD_W-1:0]) >>> DROP);
  assign in_y = SB'($signed(s_axis_tdata[2*FIELD_W-1:FIELD_W]) >>> DROP);
  assign in_z = SB'($signed(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]) >>> DROP);

  // Angle magnitude for the degree scaling
  assign mag = ang[ANGLE_W-1] ? ANGLE_W'(-ang) : ANGLE_W'(ang);

  // Select multiplier operands by sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin
        mul_a = MUL_A_W'(xs);
        mul_b = MUL_B_W'(xs);
      end
      S_SQZ: begin
        mul_a = MUL_A_W'(zs);
        mul_b = MUL_B_W'(zs);
      end
      S_DLO: begin
        mul_a = $signed({1'b0, mag[MAG_SPLIT-1:0]});
        mul_b = $signed({1'b0, DEG_Q20});
      end
      S_DHI: begin
        mul_a = $signed({1'b0, mag[2*MAG_SPLIT-1:MAG_SPLIT]});
        mul_b = $signed({1'b0, DEG_Q20});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Square root trial subtract, two radicand bits per step
  assign rem_sh = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign sq_sum = acc_m + ACC_W'(prod[MUL_P_W-2:0]);

  // CORDIC shifts and table entry
  assign sh_x = cx >>> step;
  assign sh_y = cy >>> step;
  assign tab  = atan_q32(TAB_IDX_W'(step));

  // Round the Q52 product and restore the sign
  assign deg_mag = DEG_W'(acc_m[ACC_W-1:DEG_FRAC]);
  assign deg     = ang[ANGLE_W-1] ? -$signed(deg_mag) : $signed(deg_mag);

  // Result after bias removal; a level word reads zero
  assign out_free = !out_valid || m_axis_tready;
  assign tx_next  = kind_r ? '0 : TILT_X_W'(ax - DEG_W'(bias_x));
  assign ty_next  = kind_r ? '0 : TILT_Y_W'(ay - DEG_W'(bias_y));

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bias_x    <= '0;
      bias_y    <= '0;
    end else begin
      prod <= mul_a * mul_b;
      // Raise the output word from the output step, drop it once taken
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            xs     <= in_x;
            ys     <= in_y;
            zs     <= in_z;
            kind_r <= s_axis_tuser[0];
            state  <= S_SQX;
          end
        end
        S_SQX: begin
          state <= S_SQZ;
        end
        S_SQZ: begin
          acc_m <= ACC_W'(prod[MUL_P_W-2:0]);
          state <= S_SQACC;
        end
        S_SQACC: begin
          rad   <= {sq_sum[SQ_W-1:0], (RAD_W-SQ_W)'(0)};
          rem   <= '0;
          root  <= '0;
          step  <= '0;
          state <= S_SQRT;
        end
        // One root bit per cycle
        S_SQRT: begin
          rad <= rad << 2;
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          if (int'(step) == ROOT_W - 1) begin
            sel   <= 1'b0;
            state <= S_LOAD;
          end else begin
            step <= step + 1'b1;
          end
        end
        // Pick operands for the current angle
        S_LOAD: begin
          if (!sel) begin
            cx <= CW'({1'b0, root});
            cy <= CW'(ys) <<< FRAC_BITS;
          end else begin
            cx <= CW'(zs) <<< FRAC_BITS;
            cy <= CW'(xs) <<< FRAC_BITS;
          end
          ang   <= '0;
          state <= S_PRE;
        end
        // Both zero gives angle zero; negative x turns by a quarter turn
        S_PRE: begin
          step <= '0;
          if (cx == '0 && cy == '0) begin
            state <= S_DLO;
          end else begin
            if (cx[CW-1]) begin
              if (!cy[CW-1]) begin
                cx  <= cy;
                cy  <= -cx;
                ang <= QUARTER_TURN;
              end else begin
                cx  <= -cy;
                cy  <= cx;
                ang <= -QUARTER_TURN;
              end
            end
            state <= S_ROT;
          end
        end
        // One CORDIC rotation per cycle
        S_ROT: begin
          if (!cy[CW-1]) begin
            cx  <= cx + sh_y;
            cy  <= cy - sh_x;
            ang <= ang + tab;
          end else begin
            cx  <= cx - sh_y;
            cy  <= cy + sh_x;
            ang <= ang - tab;
          end
          if (int'(step) == ANGLE_ITERATIONS - 1) begin
            state <= S_DLO;
          end else begin
            step <= step + 1'b1;
          end
        end
        // Scale to degrees in two partial products
        S_DLO: begin
          acc_m <= ACC_W'(1) << (DEG_FRAC - 1);
          state <= S_DHI;
        end
        S_DHI: begin
          acc_m <= sq_sum;
          state <= S_DACC;
        end
        S_DACC: begin
          acc_m <= acc_m + (ACC_W'(prod[MUL_P_W-2:0]) << MAG_SPLIT);
          state <= S_DSTORE;
        end
        S_DSTORE: begin
          if (!sel) begin
            ax    <= deg;
            sel   <= 1'b1;
            state <= S_LOAD;
          end else begin
            ay    <= deg;
            state <= S_OUT;
          end
        end
        // Hand the word to the output register, update biases on a level word
        S_OUT: begin
          if (out_free) begin
            out_tx    <= tx_next;
            out_ty    <= ty_next;
            if (kind_r) begin
              bias_x <= BIAS_X_W'(ax);
              bias_y <= BIAS_Y_W'(ay);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {OUT_PAD_W'(0), out_ty, out_tx};

  // A new result word appears only from the output step
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_OUT))
    else $error("output word raised outside the output step");

  // A level word always reports zero tilt
  a_level_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free && kind_r) |=> (m_axis_tdata == '0))
    else $error("level word did not give zero tilt");

  // Rotation index stays inside the iteration count
  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) |-> (int'(step) < ANGLE_ITERATIONS))
    else $error("CORDIC step beyond iteration count");

endmodule
